/* rtl/tss_pkg.sv */
// shared types, constants and reciprocal table for the taylor sine block
package tss_pkg;

    localparam int MAX_TERMS_DEF  = 16;
    localparam int FRAC_BITS      = 28;
    localparam int RECIP_BITS     = 32;
    localparam int TERM_COUNT_W   = 5;
    localparam int TERM_COUNT_RST = 8;
    localparam int ANGLE_W        = 32;
    localparam int SUM_W          = 40;
    localparam int WORD_W         = 64;
    localparam int HALF_W         = 32;
    localparam int PROD_W         = 128;
    localparam int MAG_W          = 62;
    localparam int RECIP_IDX_W    = 5;

    localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

    typedef logic [RECIP_IDX_W-1:0]  t_recip_idx;
    typedef logic [TERM_COUNT_W-1:0] t_term_count;

    typedef enum logic [1:0] {
        MSEL_SQR     = 2'd0,
        MSEL_TERM_X2 = 2'd1,
        MSEL_T_RECIP = 2'd2
    } t_mul_sel;

    typedef enum logic {
        SHIFT_FRAC  = 1'b0,
        SHIFT_RECIP = 1'b1
    } t_shift_sel;

    typedef struct packed {
        logic       x_load;
        logic       sum_clear;
        logic       mul_start;
        t_mul_sel   mul_sel;
        logic       x2_load;
        logic       term_from_x;
        logic       term_from_mul;
        logic       sum_add;
        logic       out_load;
        t_recip_idx term_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
    } t_dp_status;

    // round(2^32 / ((2n)(2n+1))), q0.32
    function automatic logic [RECIP_BITS-1:0] recip_rom(input t_recip_idx idx);
        logic [RECIP_BITS-1:0] val;
        unique case (idx)
            5'd1:    val = 32'd715827883;
            5'd2:    val = 32'd214748365;
            5'd3:    val = 32'd102261126;
            5'd4:    val = 32'd59652324;
            5'd5:    val = 32'd39045157;
            5'd6:    val = 32'd27531842;
            5'd7:    val = 32'd20452225;
            5'd8:    val = 32'd15790321;
            5'd9:    val = 32'd12558384;
            5'd10:   val = 32'd10226113;
            5'd11:   val = 32'd8488078;
            5'd12:   val = 32'd7158279;
            5'd13:   val = 32'd6118187;
            5'd14:   val = 32'd5289369;
            5'd15:   val = 32'd4618244;
            5'd16:   val = 32'd4067204;
            5'd17:   val = 32'd3609216;
            5'd18:   val = 32'd3224450;
            5'd19:   val = 32'd2898089;
            5'd20:   val = 32'd2618882;
            5'd21:   val = 32'd2378166;
            5'd22:   val = 32'd2169175;
            5'd23:   val = 32'd1986571;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/tss_mult.sv */
// multi-cycle signed multiply with floor shift and magnitude clamp
module tss_mult (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  tss_pkg::t_shift_sel               i_shift_sel,
    input  logic signed [tss_pkg::WORD_W-1:0] i_a,
    input  logic signed [tss_pkg::WORD_W-1:0] i_b,
    output logic                              o_done,
    output logic signed [tss_pkg::WORD_W-1:0] o_res
);
    import tss_pkg::*;

    logic [WORD_W-1:0]        mag_a;
    logic [WORD_W-1:0]        mag_b;
    logic [WORD_W-1:0]        r_mag_a;
    logic [WORD_W-1:0]        r_mag_b;
    logic                     r_neg;
    t_shift_sel               r_sel;
    logic                     r_busy;
    logic [2:0]               r_cnt;
    logic [1:0]               r_last;
    logic [2:0]               fin_cnt;
    logic [HALF_W-1:0]        op_a;
    logic [HALF_W-1:0]        op_b;
    logic [WORD_W-1:0]        r_pp;
    logic [1:0]               r_pp_k;
    logic                     r_pp_vld;
    logic [PROD_W-1:0]        r_acc;
    logic [PROD_W-1:0]        pp_shifted;
    logic [PROD_W-1:0]        quot;
    logic                     issue;
    logic                     finish;
    logic                     sat;
    logic                     rem;
    logic                     inc;
    logic [MAG_W-1:0]         mag;
    logic [WORD_W-1:0]        mag_w;
    logic [WORD_W-1:0]        n_res;
    logic signed [WORD_W-1:0] r_res;
    logic                     r_done;

    assign mag_a = i_a[WORD_W-1] ? WORD_W'(-i_a) : WORD_W'(i_a);
    assign mag_b = i_b[WORD_W-1] ? WORD_W'(-i_b) : WORD_W'(i_b);

    // partial product k: bit 0 picks the half of a, bit 1 the half of b
    assign fin_cnt = {1'b0, r_last} + 3'd2;
    assign issue   = r_busy && (r_cnt <= {1'b0, r_last});
    assign finish  = r_busy && (r_cnt == fin_cnt);
    assign op_a    = r_cnt[0] ? r_mag_a[WORD_W-1:HALF_W] : r_mag_a[HALF_W-1:0];
    assign op_b    = r_cnt[1] ? r_mag_b[WORD_W-1:HALF_W] : r_mag_b[HALF_W-1:0];

    always_comb begin
        unique case (r_pp_k)
            2'd0:       pp_shifted = PROD_W'(r_pp);
            2'd1, 2'd2: pp_shifted = PROD_W'(r_pp) << HALF_W;
            2'd3:       pp_shifted = PROD_W'(r_pp) << WORD_W;
        endcase
    end

    // floor of the signed quotient, magnitude clamped
    always_comb begin
        if (r_sel == SHIFT_RECIP) begin
            quot = r_acc >> RECIP_BITS;
            rem  = |r_acc[RECIP_BITS-1:0];
        end else begin
            quot = r_acc >> FRAC_BITS;
            rem  = |r_acc[FRAC_BITS-1:0];
        end
        sat   = |quot[PROD_W-1:MAG_W];
        mag   = sat ? MAG_LIMIT : quot[MAG_W-1:0];
        inc   = r_neg && rem && (mag != MAG_LIMIT);
        mag_w = {{(WORD_W-MAG_W){1'b0}}, mag};
        n_res = r_neg ? (~mag_w + WORD_W'(!inc)) : mag_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= finish;
            r_pp_vld <= issue;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag_a <= mag_a;
            r_mag_b <= mag_b;
            r_neg   <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
            r_sel   <= i_shift_sel;
            r_last  <= (mag_b[WORD_W-1:HALF_W] == '0) ? 2'd1 : 2'd3;
            r_acc   <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + pp_shifted;
        end
        if (issue) begin
            r_pp   <= WORD_W'(op_a) * WORD_W'(op_b);
            r_pp_k <= r_cnt[1:0];
        end
        if (finish) begin
            r_res <= $signed(n_res);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held longer than one cycle");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule

/* rtl/tss_dp.sv */
// datapath: angle, square, term, saturating sum and result register
module tss_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tss_pkg::t_dp_cmd                   i_cmd,
    output tss_pkg::t_dp_status                o_status,
    input  logic signed [tss_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [tss_pkg::SUM_W-1:0]   o_sine_sum,
    output logic                               o_overflow
);
    import tss_pkg::*;

    localparam int ACC_W = WORD_W + 1;

    logic signed [ANGLE_W-1:0] r_x;
    logic signed [WORD_W-1:0]  r_x2;
    logic signed [WORD_W-1:0]  r_term;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_ovf;
    logic signed [SUM_W-1:0]   r_out_sum;
    logic                      r_out_ovf;
    logic signed [WORD_W-1:0]  mul_a;
    logic signed [WORD_W-1:0]  mul_b;
    t_shift_sel                mul_shift;
    logic                      mul_done;
    logic signed [WORD_W-1:0]  mul_res;
    logic signed [ACC_W-1:0]   sum_ext;
    logic                      sum_fits;
    logic signed [SUM_W-1:0]   n_sum;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MSEL_SQR: begin
                mul_a     = WORD_W'(r_x);
                mul_b     = WORD_W'(r_x);
                mul_shift = SHIFT_FRAC;
            end
            MSEL_TERM_X2: begin
                mul_a     = r_term;
                mul_b     = r_x2;
                mul_shift = SHIFT_FRAC;
            end
            MSEL_T_RECIP: begin
                mul_a     = mul_res;
                mul_b     = $signed(WORD_W'(recip_rom(i_cmd.term_idx)));
                mul_shift = SHIFT_RECIP;
            end
            default: begin
                mul_a     = '0;
                mul_b     = '0;
                mul_shift = SHIFT_FRAC;
            end
        endcase
    end

    tss_mult u_mult (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.mul_start),
        .i_shift_sel (mul_shift),
        .i_a         (mul_a),
        .i_b         (mul_b),
        .o_done      (mul_done),
        .o_res       (mul_res)
    );

    // clamp to the q11 range when the upper bits are not all sign
    always_comb begin
        sum_ext  = ACC_W'(r_sum) + ACC_W'(r_term);
        sum_fits = (&sum_ext[ACC_W-1:SUM_W-1]) || !(|sum_ext[ACC_W-1:SUM_W-1]);
        if (sum_fits) begin
            n_sum = sum_ext[SUM_W-1:0];
        end else if (sum_ext[ACC_W-1]) begin
            n_sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            n_sum = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_x <= i_angle;
        end
        if (i_cmd.x2_load) begin
            r_x2 <= mul_res;
        end
        if (i_cmd.term_from_x) begin
            r_term <= WORD_W'(r_x);
        end else if (i_cmd.term_from_mul) begin
            r_term <= -mul_res;
        end
        if (i_cmd.sum_clear) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.sum_add) begin
            r_sum <= n_sum;
            r_ovf <= r_ovf | !sum_fits;
        end
        if (i_cmd.out_load) begin
            r_out_sum <= r_sum;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_status.mul_done = mul_done;
    assign o_sine_sum        = r_out_sum;
    assign o_overflow        = r_out_ovf;

endmodule

/* rtl/tss_ctrl.sv */
// sequencer: handshakes, term count register and series loop control
module tss_ctrl #(
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_angle_valid,
    output logic                 o_angle_ready,
    output logic                 o_result_valid,
    input  logic                 i_result_ready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  tss_pkg::t_term_count i_cfg_term_count,
    output tss_pkg::t_dp_cmd     o_cmd,
    input  tss_pkg::t_dp_status  i_status
);
    import tss_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_SQR   = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_MUL1  = 7'b0010000,
        S_MUL2  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_term_count        r_term_count;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   n_n;
    logic [CNT_W-1:0]   n_inc;
    logic [CNT_W-1:0]   clamp_count;
    logic               r_out_vld;
    logic               n_out_vld;
    t_dp_cmd            cmd;

    assign clamp_count = (r_term_count > TERM_COUNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                                    : CNT_W'(r_term_count);
    assign n_inc       = r_n + CNT_W'(1);

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MSEL_SQR;
        cmd.term_idx = RECIP_IDX_W'(r_n);
        n_state      = r_state;
        n_count      = r_count;
        n_n          = r_n;
        n_out_vld    = r_out_vld && !i_result_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_angle_valid) begin
                    cmd.x_load    = 1'b1;
                    cmd.sum_clear = 1'b1;
                    n_count       = clamp_count;
                    n_n           = '0;
                    n_state       = (clamp_count == '0) ? S_DONE : S_START;
                end
            end
            S_START: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_SQR;
                n_state       = S_SQR;
            end
            S_SQR: begin
                if (i_status.mul_done) begin
                    cmd.x2_load     = 1'b1;
                    cmd.term_from_x = 1'b1;
                    n_state         = S_ADD;
                end
            end
            S_ADD: begin
                cmd.sum_add = 1'b1;
                n_n         = n_inc;
                if (n_inc == r_count) begin
                    n_state = S_DONE;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_TERM_X2;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                if (i_status.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_T_RECIP;
                    n_state       = S_MUL2;
                end
            end
            S_MUL2: begin
                if (i_status.mul_done) begin
                    cmd.term_from_mul = 1'b1;
                    n_state           = S_ADD;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_result_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_COUNT_W'(TERM_COUNT_RST);
            r_count      <= '0;
            r_n          <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_n       <= n_n;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_term_count <= i_cfg_term_count;
            end
        end
    end

    assign o_cmd          = cmd;
    assign o_angle_ready  = (r_state == S_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_cfg_ready    = 1'b1;

    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= r_count)
        else $error("term index ran past the term count");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.mul_done |-> (r_state == S_SQR || r_state == S_MUL1 || r_state == S_MUL2))
        else $error("multiplier finished while no product was awaited");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !r_out_vld |=> r_out_vld && (r_state == S_IDLE))
        else $error("finished sum not posted to an empty output register");

endmodule

/* rtl/taylor_sine_series.sv */
// top level of the fixed-point taylor series sine block
//
// usage:
// - angle channel: i_angle (signed q3.28 radians) with i_angle_valid / o_angle_ready;
//   one request is taken while the sequencer is idle
// - result channel: o_sine_sum (signed q11.28, saturated) and o_overflow with
//   o_result_valid / i_result_ready; one result per angle, in order
// - config channel: i_cfg_term_count with i_cfg_valid / o_cfg_ready (always ready);
//   write only while no angle is in flight, values above MAX_TERMS act as MAX_TERMS
// - zero terms skip the multiplier and post the cleared sum; otherwise x^2 is formed first,
//   then each further term needs the term times x^2 product and the reciprocal product
// - per-term cost is set by the single 32x32 multiplier: the term times x^2 product
//   takes 4 partial products (2 when x^2 < 2^32), the reciprocal product 2
// - the next angle is taken the cycle after the result enters the output register,
//   so a result waiting on a stalled receiver does not block the next request;
//   a second finished sum waits in the sequencer until the receiver takes the first
// - reset (synchronous, active low) returns the sequencer to idle, drops any
//   pending result and sets the term count to 8
module taylor_sine_series #(
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_angle_valid,
    output logic                               o_angle_ready,
    input  logic signed [tss_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic signed [tss_pkg::SUM_W-1:0]   o_sine_sum,
    output logic                               o_overflow,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  tss_pkg::t_term_count               i_cfg_term_count
);
    import tss_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: term loop, handshakes and the term count register
    tss_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_angle_valid    (i_angle_valid),
        .o_angle_ready    (o_angle_ready),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_term_count (i_cfg_term_count),
        .o_cmd            (dp_cmd),
        .i_status         (dp_status)
    );

    // datapath: x^2, term recurrence through the shared multiplier, clamped sum
    tss_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_angle    (i_angle),
        .o_sine_sum (o_sine_sum),
        .o_overflow (o_overflow)
    );

endmodule

/* sim/testbench.sv */
// testbench for the taylor sine block: directed and random angles against a bit-exact predictor
module testbench;

    import tss_pkg::*;

    // run limits and stimulus sizing
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int TAIL_CYCLES    = 250;     // above the worst 16-term latency
    localparam int PHASE_COUNT    = 14;
    localparam int PHASE_ITEMS    = 99;
    localparam int CALM_PHASE     = 5;       // no send gaps or receiver stalls here
    localparam int REPORT_LIMIT   = 10;
    localparam int IDLE_PERCENT   = 30;

    // predictor constants, q3.28 angle in, q11.28 sum out
    localparam logic [63:0]        TERM_MAG_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_HI       = 64'sd549755813887;
    localparam logic signed [63:0] SUM_LO       = -64'sd549755813888;
    localparam logic signed [31:0] ANGLE_PI     = 32'sd843314857;
    localparam logic signed [31:0] ANGLE_HALF_PI = 32'sd421657428;

    // one expected result, with the request that caused it for the report
    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        int unsigned               terms;
        logic signed [SUM_W-1:0]   sum;
        logic                      ovf;
    } t_sine_expect;

    // predicts the partial sine sum per request and checks the results in order
    class sine_scoreboard;
        t_sine_expect expect_q[$];
        t_term_count  terms;
        int           fail_count;

        function new();
            terms      = t_term_count'(TERM_COUNT_RST);
            fail_count = 0;
        endfunction

        function void set_terms(t_term_count v);
            terms = v;
        endfunction

        function int pending();
            return expect_q.size();
        endfunction

        // floor(a*b / 2^sh) with the magnitude clamped to 2^62-1
        function logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                    logic signed [63:0] b,
                                                    int unsigned sh);
            logic         neg;
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] prod;
            logic [127:0] quo;
            logic [127:0] rem_bits;
            logic [63:0]  mag;
            neg      = a[63] != b[63];
            ua       = a[63] ? ~a + 64'd1 : a;
            ub       = b[63] ? ~b + 64'd1 : b;
            prod     = {64'd0, ua} * {64'd0, ub};
            quo      = prod >> sh;
            rem_bits = prod & ((128'd1 << sh) - 128'd1);
            if (quo > {64'd0, TERM_MAG_MAX}) begin
                mag = TERM_MAG_MAX;
            end else begin
                mag = quo[63:0];
                // negative products round toward minus infinity
                if (neg && rem_bits != 128'd0 && mag < TERM_MAG_MAX) begin
                    mag = mag + 64'd1;
                end
            end
            return neg ? $signed(64'd0 - mag) : $signed(mag);
        endfunction

        // rounded q0.32 reciprocal of (2n)(2n+1)
        function logic [63:0] recip_entry(int unsigned n);
            logic [63:0] d;
            d = 64'(2 * n) * 64'(2 * n + 1);
            return ((64'd1 << RECIP_BITS) + d / 64'd2) / d;
        endfunction

        function void note_angle(logic signed [ANGLE_W-1:0] angle);
            t_sine_expect      e;
            logic signed [63:0] x;
            logic signed [63:0] x2;
            logic signed [63:0] term;
            logic signed [63:0] sum;
            logic signed [63:0] step;
            int unsigned       count;
            count = (terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : terms;
            x     = angle;
            x2    = scaled_product(x, x, FRAC_BITS);
            term  = x;
            sum   = '0;
            e.ovf = 1'b0;
            for (int unsigned n = 0; n < count; n++) begin
                if (n > 0) begin
                    step = scaled_product(term, x2, FRAC_BITS);
                    step = scaled_product(step, $signed(recip_entry(n)), RECIP_BITS);
                    term = -step;
                end
                sum = sum + term;
                // the flag sticks even if the sum comes back into range
                if (sum > SUM_HI) begin
                    sum   = SUM_HI;
                    e.ovf = 1'b1;
                end else if (sum < SUM_LO) begin
                    sum   = SUM_LO;
                    e.ovf = 1'b1;
                end
            end
            e.angle = angle;
            e.terms = count;
            e.sum   = sum[SUM_W-1:0];
            expect_q.push_back(e);
        endfunction

        function void check_result(logic signed [SUM_W-1:0] sum, logic ovf);
            t_sine_expect e;
            if (expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected result: sum %0d overflow %0b", sum, ovf);
                end
                return;
            end
            e = expect_q.pop_front();
            if (sum !== e.sum || ovf !== e.ovf) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("mismatch: angle %0d terms %0d expected sum %0d ovf %0b, got sum %0d ovf %0b",
                             e.angle, e.terms, e.sum, e.ovf, sum, ovf);
                end
            end
        endfunction
    endclass

    // block ports, all inputs known from time zero
    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_angle_valid    = 1'b0;
    logic                      o_angle_ready;
    logic signed [ANGLE_W-1:0] i_angle          = '0;
    logic                      o_result_valid;
    logic                      i_result_ready   = 1'b0;
    logic signed [SUM_W-1:0]   o_sine_sum;
    logic                      o_overflow;
    logic                      i_cfg_valid      = 1'b0;
    logic                      o_cfg_ready;
    t_term_count               i_cfg_term_count = '0;

    sine_scoreboard sb;
    logic           calm        = 1'b0;
    int             cycle_count = 0;

    taylor_sine_series dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_angle_valid    (i_angle_valid),
        .o_angle_ready    (o_angle_ready),
        .i_angle          (i_angle),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .o_sine_sum       (o_sine_sum),
        .o_overflow       (o_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_term_count (i_cfg_term_count)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // safety net against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver stalls about 30 percent of cycles, never in the calm stretch
    always @(negedge i_clk) begin
        i_result_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // results are taken on the rising edge where valid and ready meet
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready) begin
            sb.check_result(o_sine_sum, o_overflow);
        end
    end

    // a tenth extremes, four tenths in-range angles, the other half anywhere in 32 bits
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        logic signed [ANGLE_W-1:0] a;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       a = 32'sh7FFF_FFFF;
                    1:       a = 32'sh8000_0000;
                    2:       a = '0;
                    3:       a = 32'sd1;
                    default: a = -32'sd1;
                endcase
            end
            1, 2, 3, 4: begin
                a = $signed($urandom_range(2 * ANGLE_PI)) - ANGLE_PI;
            end
            default: a = $urandom;
        endcase
        return a;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
        int gap;
        // occasional gap of random length so it lands on any point of the iteration
        if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            gap = $urandom_range(1, 40);
            i_angle_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_angle_valid <= 1'b1;
        i_angle       <= a;
        do begin
            @(posedge i_clk);
        end while (!o_angle_ready);
        sb.note_angle(a);
        @(negedge i_clk);
    endtask

    // drop valid and hold off until every request has its result
    task automatic wait_drained();
        i_angle_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // term count is only changed with nothing in flight
    task automatic write_terms(input t_term_count v);
        wait_drained();
        i_cfg_valid      <= 1'b1;
        i_cfg_term_count <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_terms(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic signed [ANGLE_W-1:0] directed[$];
        t_term_count               phase_terms;

        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests at the reset term count of 8
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     ANGLE_HALF_PI, -ANGLE_HALF_PI, ANGLE_PI, -ANGLE_PI,
                     2 * ANGLE_PI, -2 * ANGLE_PI, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh1000_0000, 32'shF000_0000, 32'sh4000_0000, 32'sh0001_0000};
        foreach (directed[i]) begin
            send_angle(directed[i]);
        end

        // phases: zero terms, one term, max, all ones, just over max, then random
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       phase_terms = t_term_count'(0);
                1:       phase_terms = t_term_count'(1);
                2:       phase_terms = t_term_count'(MAX_TERMS_DEF);
                3:       phase_terms = '1;
                4:       phase_terms = t_term_count'(MAX_TERMS_DEF + 1);
                default: phase_terms = t_term_count'($urandom_range(31));
            endcase
            write_terms(phase_terms);
            calm = (p == CALM_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // now and then the sender holds off until everything has come back
                if ($urandom_range(39) == 0) begin
                    wait_drained();
                end
                send_angle(pick_angle());
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tss_pkg.sv
rtl/tss_mult.sv
rtl/tss_dp.sv
rtl/tss_ctrl.sv
rtl/taylor_sine_series.sv
sim/testbench.sv
